// File: sv/sftg_pkg.sv
// ----------------------------------------------------------------------------
// sftg_pkg: stroke font label generator shared definitions
// Stroke tables, digit masks, scaling helpers and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none
package sftg_pkg;

   localparam int CoordWidth = 24;
   localparam int SizeWidth = 16;
   localparam int StrokeCount = 105;
   localparam int SegIdxWidth = 7;

   // stroke endpoint fractions: x in hundredths of size, y in ten-thousandths
   typedef struct packed {
      logic [6:0]  x0;
      logic [14:0] y0;
      logic [6:0]  x1;
      logic [14:0] y1;
   } stroke_type;

   // controller to datapath commands
   typedef struct packed {
      logic                   load;     // capture item, load cursor if label start
      logic                   emit;     // compute endpoints of the current stroke
      logic                   advance;  // move cursor after the character
      logic [SegIdxWidth-1:0] stroke;   // unified stroke index
      logic                   last;     // flag final segment
   } cmd_type;

   function automatic stroke_type mk(input int x0, input int y0, input int x1,
                                     input int y1);
      stroke_type s;
      s.x0 = 7'(x0);
      s.y0 = 15'(y0 * 165);
      s.x1 = 7'(x1);
      s.y1 = 15'(y1 * 165);
      return s;
   endfunction

   function automatic stroke_type raw(input int x0, input int y0, input int x1,
                                      input int y1);
      stroke_type s;
      s.x0 = 7'(x0);
      s.y0 = 15'(y0);
      s.x1 = 7'(x1);
      s.y1 = 15'(y1);
      return s;
   endfunction

   // stroke table: letters at 0..104, seven segments at 105..111,
   // period 112, slash 113, dash 114
   localparam int SegBase = 105;
   localparam int DotIdx = 112;
   localparam int SlashIdx = 113;
   localparam int DashIdx = 114;

   function automatic stroke_type stroke_lookup(input logic [SegIdxWidth-1:0] idx);
      stroke_type s;
      unique case (idx)
         7'd0: s = mk(0,100,0,0);     7'd1: s = mk(100,100,100,0);
         7'd2: s = mk(0,0,100,0);     7'd3: s = mk(0,50,100,50);
         7'd4: s = mk(0,100,0,0);     7'd5: s = mk(0,0,82,0);
         7'd6: s = mk(82,0,100,16);   7'd7: s = mk(100,16,100,42);
         7'd8: s = mk(100,42,82,50);  7'd9: s = mk(0,50,82,50);
         7'd10: s = mk(82,50,100,62); 7'd11: s = mk(100,62,100,88);
         7'd12: s = mk(100,88,82,100); 7'd13: s = mk(0,100,82,100);
         7'd14: s = mk(100,0,0,0);    7'd15: s = mk(0,0,0,100);
         7'd16: s = mk(0,100,100,100);
         7'd17: s = mk(0,100,0,0);    7'd18: s = mk(0,0,78,0);
         7'd19: s = mk(78,0,100,20);  7'd20: s = mk(100,20,100,80);
         7'd21: s = mk(100,80,78,100); 7'd22: s = mk(0,100,78,100);
         7'd23: s = mk(100,0,0,0);    7'd24: s = mk(0,0,0,100);
         7'd25: s = mk(0,50,82,50);   7'd26: s = mk(0,100,100,100);
         7'd27: s = mk(0,100,0,0);    7'd28: s = mk(0,0,100,0);
         7'd29: s = mk(0,50,82,50);
         7'd30: s = mk(100,0,0,0);    7'd31: s = mk(0,0,0,100);
         7'd32: s = mk(0,100,100,100); 7'd33: s = mk(100,100,100,55);
         7'd34: s = mk(100,55,56,55);
         7'd35: s = mk(0,0,0,100);    7'd36: s = mk(100,0,100,100);
         7'd37: s = mk(0,50,100,50);
         7'd38: s = mk(0,0,100,0);    7'd39: s = mk(50,0,50,100);
         7'd40: s = mk(0,100,100,100);
         7'd41: s = mk(0,0,100,0);    7'd42: s = mk(72,0,72,82);
         7'd43: s = mk(72,82,54,100); 7'd44: s = mk(54,100,12,100);
         7'd45: s = mk(12,100,0,84);
         7'd46: s = mk(0,0,0,100);    7'd47: s = mk(100,0,0,55);
         7'd48: s = mk(0,55,100,100);
         7'd49: s = mk(0,0,0,100);    7'd50: s = mk(0,100,100,100);
         7'd51: s = mk(0,100,0,0);    7'd52: s = mk(0,0,50,42);
         7'd53: s = mk(50,42,100,0);  7'd54: s = mk(100,0,100,100);
         7'd55: s = mk(0,100,0,0);    7'd56: s = mk(0,0,100,100);
         7'd57: s = mk(100,100,100,0);
         7'd58: s = mk(0,0,100,0);    7'd59: s = mk(100,0,100,100);
         7'd60: s = mk(100,100,0,100); 7'd61: s = mk(0,100,0,0);
         7'd62: s = mk(0,100,0,0);    7'd63: s = mk(0,0,86,0);
         7'd64: s = mk(86,0,100,16);  7'd65: s = mk(100,16,100,42);
         7'd66: s = mk(100,42,86,50); 7'd67: s = mk(0,50,86,50);
         7'd68: s = mk(0,0,100,0);    7'd69: s = mk(100,0,100,82);
         7'd70: s = mk(100,82,82,100); 7'd71: s = mk(82,100,0,100);
         7'd72: s = mk(0,100,0,0);    7'd73: s = mk(56,68,100,108);
         7'd74: s = mk(0,100,0,0);    7'd75: s = mk(0,0,84,0);
         7'd76: s = mk(84,0,100,16);  7'd77: s = mk(100,16,100,42);
         7'd78: s = mk(100,42,84,50); 7'd79: s = mk(0,50,84,50);
         7'd80: s = mk(42,50,100,100);
         7'd81: s = mk(100,0,0,0);    7'd82: s = mk(0,0,0,50);
         7'd83: s = mk(0,50,100,50);  7'd84: s = mk(100,50,100,100);
         7'd85: s = mk(100,100,0,100);
         7'd86: s = mk(0,0,100,0);    7'd87: s = mk(50,0,50,100);
         7'd88: s = mk(0,0,0,100);    7'd89: s = mk(0,100,100,100);
         7'd90: s = mk(100,100,100,0);
         7'd91: s = mk(0,0,50,100);   7'd92: s = mk(50,100,100,0);
         7'd93: s = mk(0,0,22,100);   7'd94: s = mk(22,100,50,58);
         7'd95: s = mk(50,58,78,100); 7'd96: s = mk(78,100,100,0);
         7'd97: s = mk(0,0,100,100);  7'd98: s = mk(100,0,0,100);
         7'd99: s = mk(0,0,50,50);    7'd100: s = mk(100,0,50,50);
         7'd101: s = mk(50,50,50,100);
         7'd102: s = mk(0,0,100,0);   7'd103: s = mk(100,0,0,100);
         7'd104: s = mk(0,100,100,100);
         7'd105: s = mk(0,0,100,0);   7'd106: s = mk(100,0,100,50);
         7'd107: s = mk(100,50,100,100); 7'd108: s = mk(0,100,100,100);
         7'd109: s = mk(0,50,0,100);  7'd110: s = mk(0,0,0,50);
         7'd111: s = mk(0,50,100,50);
         7'd112: s = raw(35,15500,38,15500);
         7'd113: s = raw(0,16500,100,0);
         7'd114: s = raw(0,8200,100,8200);
         default: s = '0;
      endcase
      return s;
   endfunction

   // first stroke of each letter, index 26 closes the table
   function automatic logic [SegIdxWidth-1:0] letter_start(input logic [4:0] i);
      logic [SegIdxWidth-1:0] r;
      unique case (i)
         5'd0: r = 7'd0;   5'd1: r = 7'd4;   5'd2: r = 7'd14;  5'd3: r = 7'd17;
         5'd4: r = 7'd23;  5'd5: r = 7'd27;  5'd6: r = 7'd30;  5'd7: r = 7'd35;
         5'd8: r = 7'd38;  5'd9: r = 7'd41;  5'd10: r = 7'd46; 5'd11: r = 7'd49;
         5'd12: r = 7'd51; 5'd13: r = 7'd55; 5'd14: r = 7'd58; 5'd15: r = 7'd62;
         5'd16: r = 7'd68; 5'd17: r = 7'd74; 5'd18: r = 7'd81; 5'd19: r = 7'd86;
         5'd20: r = 7'd88; 5'd21: r = 7'd91; 5'd22: r = 7'd93; 5'd23: r = 7'd97;
         5'd24: r = 7'd99; 5'd25: r = 7'd102; 5'd26: r = 7'd105;
         default: r = 7'd105;
      endcase
      return r;
   endfunction

   function automatic logic [6:0] digit_mask(input logic [3:0] d);
      logic [6:0] m;
      unique case (d)
         4'd0: m = 7'h3F; 4'd1: m = 7'h06; 4'd2: m = 7'h5B; 4'd3: m = 7'h4F;
         4'd4: m = 7'h66; 4'd5: m = 7'h6D; 4'd6: m = 7'h7D; 4'd7: m = 7'h07;
         4'd8: m = 7'h7F; 4'd9: m = 7'h6F;
         default: m = 7'h00;
      endcase
      return m;
   endfunction

   // saturate a 26-bit signed sum to the coordinate range
   function automatic logic [CoordWidth-1:0] sat(input logic signed [25:0] v);
      logic [CoordWidth-1:0] r;
      if (v > 26'sd8388607) r = 24'h7FFFFF;
      else if (v < -26'sd8388608) r = 24'h800000;
      else r = v[CoordWidth-1:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// File: sv/sftg_ctrl.sv
// ----------------------------------------------------------------------------
// sftg_ctrl: sequencer for the stroke font label generator
// Walks the strokes of one character and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none
module sftg_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [7:0]       char_code,
   input  wire logic             out_busy,    // output register full and not taken
   input  wire logic             res_valid,   // datapath result stage full
   output sftg_pkg::cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EMIT = 2'd1;
   localparam logic [1:0] ST_ADV  = 2'd2;

   logic [1:0] state_ff, state_in;
   // kind: 0 letter/single range, 1 mask of segments
   logic       mask_mode_ff, mask_mode_in;
   logic [6:0] mask_ff, mask_in;
   logic [sftg_pkg::SegIdxWidth-1:0] idx_ff, idx_in, end_ff, end_in;

   logic [7:0] ch;
   logic [6:0] m_next;
   logic [2:0] seg_pos;
   logic       have;
   logic [sftg_pkg::SegIdxWidth-1:0] cur;
   logic       is_last;
   logic       step;

   assign ch = char_code;

   // lowest set mask bit picks the segment
   always_comb begin
      seg_pos = 3'd0;
      for (int i = 6; i >= 0; i--) begin
         if (mask_ff[i]) seg_pos = 3'(i);
      end
   end

   assign m_next = mask_ff & (mask_ff - 7'd1);
   assign cur = mask_mode_ff ? 7'(sftg_pkg::SegBase + 32'(seg_pos)) : idx_ff;
   assign is_last = mask_mode_ff ? (m_next == 7'd0) : (idx_ff + 7'd1 == end_ff);
   assign have = mask_mode_ff ? (mask_ff != 7'd0) : (idx_ff != end_ff);
   assign step = !(out_busy && res_valid);
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      mask_mode_in = mask_mode_ff;
      mask_in = mask_ff;
      idx_in = idx_ff;
      end_in = end_ff;
      cmd = '0;
      cmd.stroke = cur;
      cmd.last = is_last;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EMIT;
               mask_mode_in = 1'b0;
               mask_in = '0;
               idx_in = '0;
               end_in = '0;
               if (ch >= 8'h30 && ch <= 8'h39) begin
                  mask_mode_in = 1'b1;
                  mask_in = sftg_pkg::digit_mask(4'(ch - 8'h30));
               end else if (ch >= 8'h41 && ch <= 8'h5A) begin
                  idx_in = sftg_pkg::letter_start(5'(ch - 8'h41));
                  end_in = sftg_pkg::letter_start(5'(ch - 8'h40));
               end else if (ch == 8'h75) begin
                  mask_mode_in = 1'b1;
                  mask_in = 7'h1C;
               end else if (ch == 8'h2E) begin
                  idx_in = 7'(sftg_pkg::DotIdx);
                  end_in = 7'(sftg_pkg::DotIdx + 1);
               end else if (ch == 8'h2F) begin
                  idx_in = 7'(sftg_pkg::SlashIdx);
                  end_in = 7'(sftg_pkg::SlashIdx + 1);
               end else if (ch == 8'h2D) begin
                  idx_in = 7'(sftg_pkg::DashIdx);
                  end_in = 7'(sftg_pkg::DashIdx + 1);
               end
            end
         end
         ST_EMIT: begin
            if (!have) begin
               state_in = ST_ADV;
            end else if (step) begin
               cmd.emit = 1'b1;
               if (mask_mode_ff) mask_in = m_next;
               else idx_in = idx_ff + 7'd1;
               if (is_last) state_in = ST_ADV;
            end
         end
         // cursor moves only when the product stage is empty or is draining into the output register
         ST_ADV: begin
            if (step) begin
               cmd.advance = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mask_mode_ff <= mask_mode_in;
      mask_ff <= mask_in;
      idx_ff <= idx_in;
      end_ff <= end_in;
   end

   // emit only while a stroke is pending
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> state_ff == ST_EMIT && have) else $error("emit without stroke");
   // a taken item is followed by the emit state
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_EMIT) else $error("load not followed by emit");
   // advance returns to idle
   assert property (@(posedge clock) disable iff (reset)
      cmd.advance |=> req_tready) else $error("advance did not finish");

endmodule
`default_nettype wire

// File: sv/sftg_dp.sv
// ----------------------------------------------------------------------------
// sftg_dp: datapath for the stroke font label generator
// Holds the cursor and item, scales stroke fractions, drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module sftg_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sftg_pkg::cmd_type    cmd,
   input  wire logic [7:0]           char_code,
   input  wire logic                 start_of_label,
   input  wire logic [23:0]          start_x,
   input  wire logic [23:0]          start_y,
   input  wire logic [15:0]          glyph_size,
   input  wire logic                 rsp_tready,
   output logic                      rsp_tvalid,
   output logic [95:0]               rsp_tdata,
   output logic                      rsp_tlast,
   output logic                      out_busy,
   output logic                      res_valid
);

   logic [23:0] cursor_ff, cursor_in;
   logic [23:0] y_ff;
   logic [15:0] size_ff;
   logic [7:0]  adv_ff, adv_in;
   logic [23:0] adv_prod_ff;

   // stage 1: products
   logic        p_valid_ff;
   logic        p_last_ff;
   logic [22:0] px0_ff, px1_ff;
   logic [30:0] py0_ff, py1_ff;
   // stage 2: output register
   logic        o_valid_ff;
   logic        o_last_ff;
   logic [95:0] o_data_ff;

   sftg_pkg::stroke_type st;
   logic [23:0] cur_eff;
   logic [16:0] ox0, ox1, oy0, oy1, oadv;
   logic        o_take;

   // divide by 100 rounded half up: (p + 50) / 4, then reciprocal of 25
   function automatic logic [16:0] div100(input logic [23:0] p);
      logic [21:0] t;
      logic [42:0] q;
      t = 22'((25'(p) + 25'd50) >> 2);
      q = 43'(t) * 43'(22'd2684355);
      return q[42:26];
   endfunction

   // divide by 10000 rounded half up: (p + 5000) / 16, then reciprocal of 625
   function automatic logic [16:0] div10000(input logic [30:0] p);
      logic [26:0] t;
      logic [54:0] q;
      t = 27'((32'(p) + 32'd5000) >> 4);
      q = 55'(t) * 55'(28'd219902326);
      return q[53:37];
   endfunction

   assign st = sftg_pkg::stroke_lookup(cmd.stroke);
   assign o_take = !o_valid_ff || rsp_tready;
   assign out_busy = !o_take;
   assign res_valid = p_valid_ff;

   // offsets rounded half up: x by 1/100, y by 1/10000
   assign ox0 = div100({1'b0, px0_ff});
   assign ox1 = div100({1'b0, px1_ff});
   assign oy0 = div10000(py0_ff);
   assign oy1 = div10000(py1_ff);
   assign oadv = div100(adv_prod_ff);

   // cursor and advance selection
   always_comb begin
      cur_eff = start_of_label ? start_x : cursor_ff;
      cursor_in = cursor_ff;
      adv_in = adv_ff;
      if (cmd.load) begin
         cursor_in = cur_eff;
         adv_in = 8'd85;
         if ((char_code >= 8'h30 && char_code <= 8'h39) ||
             (char_code >= 8'h41 && char_code <= 8'h5A) || char_code == 8'h75)
            adv_in = 8'd145;
         else if (char_code == 8'h2E) adv_in = 8'd75;
         else if (char_code == 8'h2F || char_code == 8'h2D) adv_in = 8'd105;
      end else if (cmd.advance) begin
         cursor_in = sftg_pkg::sat(26'($signed(cursor_ff)) + 26'($signed({1'b0, oadv})));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         cursor_ff <= cursor_in;
         if (cmd.emit) p_valid_ff <= 1'b1;
         else if (o_take) p_valid_ff <= 1'b0;
         if (o_take) o_valid_ff <= p_valid_ff;
      end
      adv_ff <= adv_in;
      // advance product, registered from adv_ff and settled before the advance step
      adv_prod_ff <= 24'(size_ff) * 24'(adv_ff);
      if (cmd.load) begin
         y_ff <= start_y;
         size_ff <= glyph_size;
      end
      if (cmd.emit) begin
         px0_ff <= 23'(size_ff) * 23'(st.x0);
         px1_ff <= 23'(size_ff) * 23'(st.x1);
         py0_ff <= 31'(size_ff) * 31'(st.y0);
         py1_ff <= 31'(size_ff) * 31'(st.y1);
         p_last_ff <= cmd.last;
      end
      if (o_take && p_valid_ff) begin
         o_data_ff <= {
            sftg_pkg::sat(26'($signed(y_ff)) + 26'($signed({1'b0, oy1}))),
            sftg_pkg::sat(26'($signed(cursor_ff)) + 26'($signed({1'b0, ox1}))),
            sftg_pkg::sat(26'($signed(y_ff)) + 26'($signed({1'b0, oy0}))),
            sftg_pkg::sat(26'($signed(cursor_ff)) + 26'($signed({1'b0, ox0})))};
         o_last_ff <= p_last_ff;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata = o_data_ff;
   assign rsp_tlast = o_last_ff;

   // product stage never overwritten while held
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !p_valid_ff || o_take) else $error("product stage overrun");
   // cursor moves only on load or advance
   assert property (@(posedge clock) disable iff (reset)
      !cmd.load && !cmd.advance |=> $stable(cursor_ff)) else $error("cursor drift");
   // advance only when the product stage is empty or draining into the output stage
   assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> !p_valid_ff || o_take) else $error("advance with pending product");

endmodule
`default_nettype wire

// File: sv/stroke_font_text_generator.sv
// ----------------------------------------------------------------------------
// stroke_font_text_generator: vector stroke label generator
// One character per item in, zero to ten line segments out.
// ----------------------------------------------------------------------------
// channel | ports | payload
// req     | req_tvalid/req_tready/req_tdata/req_tuser | char, x, y, size / label start
// rsp     | rsp_tvalid/rsp_tready/rsp_tdata/rsp_tlast | x0 y0 x1 y1 / last segment
// a character passes through load, a stroke step for each segment and advance;
// one with no segments through load, the emit state and advance; the stroke sequencer
// sets the rate; each segment goes through the product stage to the output register
// reset clears the cursor to zero and empties both result stages
// a stalled rsp side holds stroke steps and the advance once both stages are full;
// req waits until the character is done
// ----------------------------------------------------------------------------
`default_nettype none
module stroke_font_text_generator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // char_code[7:0], start_x[31:8], start_y[55:32],
                                        // glyph_size[71:56]
   input  wire logic        req_tuser,  // start_of_label
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,  // line_x0, line_y0, line_x1, line_y1
   output logic             rsp_tlast   // last_segment
);

   sftg_pkg::cmd_type cmd;
   logic out_busy, res_valid;

   sftg_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .char_code(req_tdata[7:0]), .out_busy(out_busy), .res_valid(res_valid),
      .cmd(cmd));

   sftg_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .char_code(req_tdata[7:0]),
      .start_of_label(req_tuser), .start_x(req_tdata[31:8]),
      .start_y(req_tdata[55:32]), .glyph_size(req_tdata[71:56]),
      .rsp_tready(rsp_tready), .rsp_tvalid(rsp_tvalid), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .out_busy(out_busy), .res_valid(res_valid));

endmodule
`default_nettype wire
